/* rtl/core/cbte_pkg.sv */
// ----------------------------------------------------------------------------
// cbte_pkg: shared types and constants of the cubic-bezier timing evaluator
// Fixed-point widths, the side-band word that travels with every word through
// the pipeline, and the reciprocal constants used for the exact divisions.
// ----------------------------------------------------------------------------
package cbte_pkg;

  // Curve parameter t in hundred-thousandths, 0..100000.
  localparam int TW       = 17;
  localparam logic [TW-1:0] T_SCALE = 17'd100000;
  localparam logic [TW-1:0] T_HALF  = 17'd50000;

  // Control coordinate width and target width (millionths, below 10^6).
  localparam int PW       = 10;
  localparam int TGW      = 20;

  // Intermediate widths of the curve evaluation.
  localparam int TTW      = 34;   // t*t
  localparam int UTW      = 32;   // u*t, at most 2.5e9
  localparam int SW       = 29;   // 3*(u*p1 + t*p2)
  localparam int CW       = 50;   // t*t*t
  localparam int AW       = 60;   // 3*u*t*(u*p1 + t*p2)
  localparam int QW       = 20;   // quotient estimates
  localparam int PAW      = 48;   // estimate times 5^12
  localparam int PCW      = 41;   // estimate times 5^9
  localparam int YW       = 21;   // curve value in millionths

  // Reciprocals: floor(2^71 / 10^12) and floor(2^60 / 10^9).
  localparam logic [31:0]     RCP_A    = 32'd2361183241;
  localparam logic [31:0]     RCP_C    = 32'd1152921504;
  localparam logic [PAW-1:0]  FIVE_12  = 48'd244140625;
  localparam logic [PCW-1:0]  FIVE_9   = 41'd1953125;
  localparam logic [AW-1:0]   DIV_A    = 60'd1000000000000;
  localparam logic [CW-1:0]   DIV_C    = 50'd1000000000;

  // Side-band word carried alongside each progress word.
  typedef struct packed {
    logic [TW-1:0]  lo;
    logic [TW-1:0]  hi;
    logic [TW-1:0]  mid;
    logic [TGW-1:0] target;
    logic           sat_lo;
    logic           sat_hi;
  } cbte_side_t;

endpackage

/* rtl/core/cbte_curve.sv */
// ----------------------------------------------------------------------------
// cbte_curve: five-stage pipelined evaluation of one bezier coordinate
// Computes (3*u*u*t*p1 + 3*u*t*t*p2) / 10^12 + t^3 / 10^9 with both divisions
// truncating, using reciprocal estimates followed by a single correction.
// ----------------------------------------------------------------------------
module cbte_curve import cbte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [TW-1:0]     t_i,
  input  logic [PW-1:0]     p1_i,
  input  logic [PW-1:0]     p2_i,
  input  cbte_side_t        side_i,
  output logic              valid_o,
  output logic [YW-1:0]     y_o,
  output cbte_side_t        side_o
);

  logic [TW-1:0]  u;
  logic [SW-1:0]  s_lin;
  logic [63:0]    qa_prod;
  logic [63:0]    qc_prod;
  logic [AW-1:0]  ra;
  logic [CW-1:0]  rc;

  logic           v1_q, v2_q, v3_q, v4_q, v5_q;
  cbte_side_t     sd1_q, sd2_q, sd3_q, sd4_q, sd5_q;
  logic [TW-1:0]  t1_q;
  logic [TTW-1:0] tt1_q;
  logic [UTW-1:0] ut1_q;
  logic [SW-1:0]  s1_q;
  logic [CW-1:0]  c2_q, c3_q, c4_q;
  logic [AW-1:0]  a2_q, a3_q, a4_q;
  logic [QW-1:0]  qa3_q, qc3_q, qa4_q, qc4_q;
  logic [PAW-1:0] pa4_q;
  logic [PCW-1:0] pc4_q;
  logic [YW-1:0]  y5_q;

  always_comb begin
    u     = T_SCALE - t_i;
    s_lin = SW'(u) * SW'(p1_i) + SW'(t_i) * SW'(p2_i);
    qa_prod = 64'(a2_q[AW-1:28]) * 64'(RCP_A);
    qc_prod = 64'(c2_q[CW-1:18]) * 64'(RCP_C);
    ra    = a4_q - {pa4_q, 12'd0};
    rc    = c4_q - {pc4_q, 9'd0};
  end

  // Valid bits of the five stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Products of t, and the linear blend of the control coordinates.
      t1_q  <= t_i;
      tt1_q <= TTW'(t_i) * TTW'(t_i);
      ut1_q <= UTW'(u) * UTW'(t_i);
      s1_q  <= (s_lin << 1) + s_lin;
      sd1_q <= side_i;
      // Full numerators.
      c2_q  <= CW'(tt1_q) * CW'(t1_q);
      a2_q  <= AW'(ut1_q) * AW'(s1_q);
      sd2_q <= sd1_q;
      // Quotient estimates, at most one below the true quotient.
      a3_q  <= a2_q;
      c3_q  <= c2_q;
      qa3_q <= qa_prod[62:43];
      qc3_q <= qc_prod[61:42];
      sd3_q <= sd2_q;
      // Back-multiplication of the estimates.
      a4_q  <= a3_q;
      c4_q  <= c3_q;
      qa4_q <= qa3_q;
      qc4_q <= qc3_q;
      pa4_q <= PAW'(qa3_q) * FIVE_12;
      pc4_q <= PCW'(qc3_q) * FIVE_9;
      sd4_q <= sd3_q;
      // Correct each estimate and add the two terms.
      y5_q  <= YW'(qa4_q) + YW'(ra >= DIV_A) + YW'(qc4_q) + YW'(rc >= DIV_C);
      sd5_q <= sd4_q;
    end
  end

  assign valid_o = v5_q;
  assign y_o     = y5_q;
  assign side_o  = sd5_q;

endmodule

/* rtl/core/cubic_bezier_timing_eval.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_timing_eval: pipelined CSS-style cubic-bezier easing curve
// Maps a progress value in thousandths to the eased value in thousandths by
// bisection on the x curve followed by one evaluation of the y curve.
// ----------------------------------------------------------------------------
// Usage. Progress words enter on the in_valid_i / in_ready_o channel and the
// eased words leave on the out_valid_o / out_ready_i channel, one result for
// each input word and in the same order. The four control coordinates are
// written through cfg_we_i, cfg_idx_i and cfg_data_i, and should only change
// while no word is in flight.
// From acceptance to eased_o, each halving passes through the curve
// evaluation and a bisection decision register; the final y evaluation,
// the rounding stage and the output register follow.
// Throughput is one word per cycle for as long as the receiver takes words.
// When the receiver stalls, the output register holds its word and one more
// word drops into a skid register; in_ready_o then falls and the whole
// pipeline freezes without losing or repeating anything, and it resumes the
// cycle after the skid register drains.
// Reset empties the pipeline and the output registers and restores the
// control points to (0.42, 0.0) and (0.58, 1.0), the usual ease-in-out curve.
// ----------------------------------------------------------------------------
module cubic_bezier_timing_eval import cbte_pkg::*; #(
  parameter int HALVINGS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] progress_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  eased_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);

  // Configuration register indexes.
  localparam logic [1:0] CFG_X1 = 2'd0;
  localparam logic [1:0] CFG_Y1 = 2'd1;
  localparam logic [1:0] CFG_X2 = 2'd2;
  localparam logic [1:0] CFG_Y2 = 2'd3;

  // Rounding by 1000: ((y + 500) >> 3) / 125 by reciprocal, exact here.
  localparam logic [18:0] RND_M  = 19'd268436;
  localparam logic [9:0]  EASE_MAX = 10'd1000;

  logic [PW-1:0] ctrl_x1_q, ctrl_y1_q, ctrl_x2_q, ctrl_y2_q;

  // Global pipeline advance: the pipeline moves whenever the skid is empty.
  logic adv;

  // Bisection state after each halving; index 0 is the entry register.
  logic       dv_q [0:HALVINGS];
  cbte_side_t ds_q [0:HALVINGS];

  // Curve outputs of each halving.
  logic          cv [0:HALVINGS-1];
  logic [YW-1:0] cy [0:HALVINGS-1];
  cbte_side_t    cs [0:HALVINGS-1];

  logic          yv;
  logic [YW-1:0] yy;
  cbte_side_t    ys;

  logic          r_v_q;
  logic [9:0]    r_eased_q;
  logic          out_v_q, sk_v_q;
  logic [9:0]    out_q, sk_q;
  logic          take;

  logic [18:0]   rnd_v;
  logic [37:0]   rnd_prod;
  logic [12:0]   rnd_q;
  logic          in_sat_lo, in_sat_hi;

  assign adv        = !sk_v_q;
  assign in_ready_o = adv;
  assign take       = out_v_q && out_ready_i;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_x1_q <= 10'd420;
      ctrl_y1_q <= 10'd0;
      ctrl_x2_q <= 10'd580;
      ctrl_y2_q <= 10'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X1: ctrl_x1_q <= cfg_data_i;
        CFG_Y1: ctrl_y1_q <= cfg_data_i;
        CFG_X2: ctrl_x2_q <= cfg_data_i;
        CFG_Y2: ctrl_y2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Entry stage: clamp detection and the bisection target in millionths.
  // --------------------------------------------------------------------------
  assign in_sat_lo = (progress_i <= 16'sd0);
  assign in_sat_hi = (progress_i >= 16'sd1000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ds_q[0].lo     <= '0;
      ds_q[0].hi     <= T_SCALE;
      ds_q[0].mid    <= T_HALF;
      ds_q[0].sat_lo <= in_sat_lo;
      ds_q[0].sat_hi <= in_sat_hi;
      // Out-of-range words never use the target, so it is simply zeroed.
      ds_q[0].target <= (in_sat_lo || in_sat_hi) ? '0
                      : TGW'(progress_i[9:0]) * TGW'(10'd1000);
    end
  end

  // --------------------------------------------------------------------------
  // Bisection halvings: evaluate x at the midpoint, then move lo or hi.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < HALVINGS; k++) begin : g_halving
    logic [TW-1:0] lo_n, hi_n;
    logic [TW:0]   sum_n;

    cbte_curve u_curve_x (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_q[k]),
      .t_i     (ds_q[k].mid),
      .p1_i    (ctrl_x1_q),
      .p2_i    (ctrl_x2_q),
      .side_i  (ds_q[k]),
      .valid_o (cv[k]),
      .y_o     (cy[k]),
      .side_o  (cs[k])
    );

    always_comb begin
      if (cy[k] < YW'(cs[k].target)) begin
        lo_n = cs[k].mid;
        hi_n = cs[k].hi;
      end else begin
        lo_n = cs[k].lo;
        hi_n = cs[k].mid;
      end
      sum_n = (TW + 1)'(lo_n) + (TW + 1)'(hi_n);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_q[k+1] <= cv[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ds_q[k+1].lo     <= lo_n;
        ds_q[k+1].hi     <= hi_n;
        ds_q[k+1].mid    <= sum_n[TW:1];
        ds_q[k+1].target <= cs[k].target;
        ds_q[k+1].sat_lo <= cs[k].sat_lo;
        ds_q[k+1].sat_hi <= cs[k].sat_hi;
      end
    end
  end

  // --------------------------------------------------------------------------
  // The y curve at the final midpoint.
  // --------------------------------------------------------------------------
  cbte_curve u_curve_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (dv_q[HALVINGS]),
    .t_i     (ds_q[HALVINGS].mid),
    .p1_i    (ctrl_y1_q),
    .p2_i    (ctrl_y2_q),
    .side_i  (ds_q[HALVINGS]),
    .valid_o (yv),
    .y_o     (yy),
    .side_o  (ys)
  );

  // --------------------------------------------------------------------------
  // Rounding to thousandths, clamping and saturation.
  // --------------------------------------------------------------------------
  always_comb begin
    rnd_v    = 19'((22'(yy) + 22'd500) >> 3);
    rnd_prod = 38'(rnd_v) * 38'(RND_M);
    rnd_q    = rnd_prod[37:25];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (adv) begin
      r_v_q <= yv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (ys.sat_lo) begin
        r_eased_q <= '0;
      end else if (ys.sat_hi || rnd_q > 13'(EASE_MAX)) begin
        r_eased_q <= EASE_MAX;
      end else begin
        r_eased_q <= rnd_q[9:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid register. A word leaving the pipeline goes to
  // the output register if that is free or being emptied, otherwise to the
  // skid register, which then freezes the pipeline until it drains.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (take) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end
    end else if (r_v_q) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        sk_v_q  <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (take) begin
        out_q <= sk_q;
      end
    end else if (r_v_q) begin
      if (!out_v_q || take) begin
        out_q <= r_eased_q;
      end else begin
        sk_q  <= r_eased_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign eased_o     = out_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // The skid register only fills while the output word is held back.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid register filled while the output was free");

  // Back-pressure to the sender only ever comes with a waiting output word.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output word pending");

  // A full skid register must drain into the output register on a take.
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sk_v_q && take) |=> (out_v_q && !sk_v_q && out_q == $past(sk_q)))
    else $error("skid word not moved to the output register");

  // Eased words never exceed one whole.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (eased_o <= EASE_MAX))
    else $error("eased word above 1000");

endmodule

/* bench/cubic_bezier_timing_eval_test.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_timing_eval_test: self-checking bench of the easing evaluator
// Drives progress words through the valid/ready input channel, predicts every
// eased word with a bit-exact bisection model, and compares each word that
// leaves the block with the oldest prediction. The control points change
// between phases, only while nothing is in flight, and cover their extremes.
// ----------------------------------------------------------------------------
module cubic_bezier_timing_eval_test;
  import cbte_pkg::*;

  // Seventeen halvings; the drain covers the pipeline latency with a margin.
  localparam int BISECT_STEPS = 17;
  localparam int DRAIN_CYCLES = 6 * BISECT_STEPS + 7 + 30;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef enum logic [1:0] {
    REG_X1 = 2'd0,
    REG_Y1 = 2'd1,
    REG_X2 = 2'd2,
    REG_Y2 = 2'd3
  } ctrl_reg_e;

  // One outstanding eased word, kept with the progress that caused it.
  typedef struct {
    logic signed [15:0] progress;
    logic [9:0]         eased;
  } ease_rec_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] progress_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [9:0]         eased_o;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_idx_i   = '0;
  logic [9:0]         cfg_data_i  = '0;

  // Words still to be offered, and eased words still owed by the block.
  logic signed [15:0] progress_q [$];
  ease_rec_t          ease_q [$];

  // Our own copy of the control points, following the register port.
  logic [PW-1:0] ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2;

  // Idling rates in percent, changed by the sequencer between phases.
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;

  int   failures    = 0;
  int   cycle_count = 0;
  logic in_taken    = 1'b0;
  int   send_gap    = 0;
  int   recv_stall  = 0;

  cubic_bezier_timing_eval #(
    .HALVINGS(BISECT_STEPS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .progress_i  (progress_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .eased_o     (eased_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Value of one axis of the curve at parameter t (hundred-thousandths), in
  // millionths. Both divisions truncate, exactly as the block must do.
  function automatic longint unsigned bezier_axis(input int unsigned t_in,
                                                  input logic [PW-1:0] c1,
                                                  input logic [PW-1:0] c2);
    longint unsigned t, u, a, b, c;
    t = t_in;
    u = 64'd100000 - t;
    a = 64'd3 * u * u * t * c1;
    b = 64'd3 * u * t * t * c2;
    c = t * t * t;
    return (a + b) / 64'd1_000_000_000_000 + c / 64'd1_000_000_000;
  endfunction

  // Eased word for one progress word under the current control points:
  // clamp, bisect on the x curve, then evaluate and round the y curve.
  function automatic logic [9:0] predict_ease(input logic signed [15:0] x);
    longint unsigned target, y_val, rounded;
    int unsigned     lo, hi, mid;
    if (x <= 16'sd0) return 10'd0;
    if (x >= 16'sd1000) return 10'd1000;
    target = 64'(x) * 64'd1000;
    lo = 0;
    hi = 100000;
    for (int i = 0; i < BISECT_STEPS; i++) begin
      mid = (lo + hi) / 2;
      if (bezier_axis(mid, ctrl_x1, ctrl_x2) < target) lo = mid;
      else hi = mid;
    end
    y_val   = bezier_axis((lo + hi) / 2, ctrl_y1, ctrl_y2);
    rounded = (y_val + 64'd500) / 64'd1000;
    // A y control above 1000 can push the curve past the top; it saturates.
    if (rounded > 64'd1000) rounded = 64'd1000;
    return rounded[9:0];
  endfunction

  // Length of an idle stretch: none unless the pct draw hits, then mostly short, rarely long.
  function automatic int draw_pause(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly progress inside the curve, some words at the clamp boundaries,
  // and some fully random 16-bit words so that every bit toggles.
  function automatic logic signed [15:0] draw_progress();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return 16'($urandom_range(1, 999));
    if (pick < 85) begin
      case ($urandom_range(7))
        0: return 16'sd1;
        1: return 16'sd2;
        2: return 16'sd998;
        3: return 16'sd999;
        4: return 16'sd0;
        5: return 16'sd1000;
        6: return -16'sd1;
        default: return 16'sd1001;
      endcase
    end
    return 16'($urandom());
  endfunction

  // A control coordinate, with a fair share of the extremes, including 1023,
  // a value above 1000 that the 10-bit register still accepts.
  function automatic logic [9:0] draw_ctrl();
    case ($urandom_range(9))
      0: return 10'd0;
      1: return 10'd1000;
      2: return 10'd1023;
      default: return 10'($urandom_range(0, 1000));
    endcase
  endfunction

  // Track the control registers at the port, and predict each accepted word.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      ctrl_x1 <= 10'd420;
      ctrl_y1 <= 10'd0;
      ctrl_x2 <= 10'd580;
      ctrl_y2 <= 10'd1000;
      in_taken <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (ctrl_reg_e'(cfg_idx_i))
          REG_X1: ctrl_x1 <= cfg_data_i;
          REG_Y1: ctrl_y1 <= cfg_data_i;
          REG_X2: ctrl_x2 <= cfg_data_i;
          REG_Y2: ctrl_y2 <= cfg_data_i;
          default: ;
        endcase
      end
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o)
        ease_q.push_back('{progress: progress_i, eased: predict_ease(progress_i)});
    end
  end

  // Sender: a word stays on the channel until taken, then an optional gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_taken)) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap = send_gap - 1;
      end else if (progress_q.size() != 0) begin
        in_valid_i <= 1'b1;
        progress_i <= progress_q.pop_front();
        send_gap = draw_pause(sender_idle_pct);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: ready for one cycle at least between stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (recv_stall > 0) begin
      out_ready_i <= 1'b0;
      recv_stall = recv_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      recv_stall = draw_pause(receiver_idle_pct);
    end
  end

  // Every word leaving the block must match the oldest outstanding prediction.
  always @(posedge clk_i) begin : check_eased
    ease_rec_t owed;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ease_q.size() == 0) begin
        $display("%0t: eased word %0d arrived with none outstanding", $time, eased_o);
        failures = failures + 1;
      end else begin
        owed = ease_q.pop_front();
        if (eased_o !== owed.eased) begin
          $display("%0t: progress %0d: eased expected %0d, actual %0d",
                   $time, owed.progress, owed.eased, eased_o);
          failures = failures + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Block until every queued word has been taken and every eased word seen.
  // Since each word yields exactly one result, the block is then empty.
  task automatic wait_until_idle();
    while (progress_q.size() != 0 || in_valid_i || ease_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_ctrl(input ctrl_reg_e idx, input logic [9:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One phase: new control points, new idling rates, a batch of random words.
  task automatic run_phase(input logic [9:0] x1, input logic [9:0] y1,
                           input logic [9:0] x2, input logic [9:0] y2,
                           input int send_pct, input int recv_pct, input int words);
    write_ctrl(REG_X1, x1);
    write_ctrl(REG_Y1, y1);
    write_ctrl(REG_X2, x2);
    write_ctrl(REG_Y2, y2);
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    for (int i = 0; i < words; i++) progress_q.push_back(draw_progress());
    wait_until_idle();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words on the reset curve, with no idling on either side: both
    // clamps and their neighbours, the extremes of the 16-bit field, a few
    // points inside the curve and two alternating bit patterns.
    progress_q = '{-16'sd32768, -16'sd1000, -16'sd1, 16'sd0, 16'sd1, 16'sd2,
                   16'sd250, 16'sd500, 16'sd750, 16'sd998, 16'sd999, 16'sd1000,
                   16'sd1001, 16'sd32767, 16'sh5555, 16'shAAAA, 16'sd333};
    wait_until_idle();

    // Corner curves: flat, full, everything at the top of the register (where
    // the y curve overshoots and saturates), and crossed control points.
    run_phase(10'd0,    10'd0,    10'd0,    10'd0,    30, 30, 150);
    run_phase(10'd1000, 10'd1000, 10'd1000, 10'd1000, 0,  0,  150);
    run_phase(10'd1023, 10'd1023, 10'd1023, 10'd1023, 50, 10, 150);
    run_phase(10'd0,    10'd1023, 10'd1023, 10'd0,    10, 60, 150);
    run_phase(10'd1023, 10'd0,    10'd0,    10'd1023, 40, 40, 150);

    // Random curves with random idling; each phase drains fully before the
    // next register write, so the sender also waits for every result.
    for (int p = 0; p < 7; p++)
      run_phase(draw_ctrl(), draw_ctrl(), draw_ctrl(), draw_ctrl(),
                $urandom_range(0, 60), $urandom_range(0, 60), 150);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
